@@ rtl/pfet_pkg.sv @@
// shared types, constants and the arctangent table of the polar fix block
`timescale 1ns / 1ps
`default_nettype none

package pfet_pkg;

    localparam int ID_W          = 8;
    localparam int CORDIC_STAGES = 16;

    localparam int TRACK_W    = 8;
    localparam int ID_CMP_W   = (ID_W < TRACK_W) ? ID_W : TRACK_W;
    localparam int XY_W       = 35;
    localparam int Z_W        = 25;
    localparam int DLY_DEPTH  = CORDIC_STAGES - 5;

    localparam int FULL_TURN    = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;
    localparam int GAIN_Q16     = 39797;
    localparam int Q8_MAX       = 65535;
    localparam int DAY_SEC      = 24 * 60 * 60;

    localparam int DIV10K_MUL = 429497;
    localparam int DIV100_MUL = 5243;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_vec;

    typedef struct packed {
        logic [TRACK_W-1:0] id;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [16:0]        elapsed;
        logic               invalid;
    } t_tinfo;

    function automatic logic signed [Z_W-1:0] atan_deg16(input logic [4:0] idx);
        int v;
        case (idx)
            5'd0:    v = 2949120;
            5'd1:    v = 1740967;
            5'd2:    v = 919879;
            5'd3:    v = 466945;
            5'd4:    v = 234379;
            5'd5:    v = 117304;
            5'd6:    v = 58666;
            5'd7:    v = 29335;
            5'd8:    v = 14668;
            5'd9:    v = 7334;
            5'd10:   v = 3667;
            5'd11:   v = 1833;
            5'd12:   v = 917;
            5'd13:   v = 458;
            5'd14:   v = 229;
            5'd15:   v = 115;
            5'd16:   v = 57;
            5'd17:   v = 29;
            5'd18:   v = 14;
            5'd19:   v = 7;
            5'd20:   v = 4;
            5'd21:   v = 2;
            5'd22:   v = 1;
            default: v = 0;
        endcase
        return Z_W'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/pfet_front.sv @@
// heading reduction, start vector scaling and first pipeline register
`timescale 1ns / 1ps
`default_nettype none

module pfet_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [16:0]   i_heading,
    input  wire logic [15:0]   i_distance,
    output logic               o_valid,
    output pfet_pkg::t_vec     o_vec
);

    logic [16:0]        w_a1;
    logic signed [17:0] w_a2;
    logic signed [17:0] w_a3;
    logic               w_flip;

    logic                                r_vld;
    logic                                r_flip;
    logic [31:0]                         r_prod;
    logic signed [pfet_pkg::Z_W-1:0]     r_z;
    logic signed [pfet_pkg::XY_W-1:0]    w_x0;

    always_comb begin
        w_a1 = (i_heading >= 17'(pfet_pkg::FULL_TURN))
             ? i_heading - 17'(pfet_pkg::FULL_TURN) : i_heading;
        w_a2 = (w_a1 >= 17'(pfet_pkg::HALF_TURN))
             ? $signed({1'b0, w_a1}) - 18'sd92160 : $signed({1'b0, w_a1});
        w_a3   = w_a2;
        w_flip = 1'b0;
        if (w_a2 > 18'sd23040) begin
            w_a3   = w_a2 - 18'sd46080;
            w_flip = 1'b1;
        end else if (w_a2 < -18'sd23040) begin
            w_a3   = w_a2 + 18'sd46080;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip <= w_flip;
            r_prod <= 32'(i_distance) * 32'(pfet_pkg::GAIN_Q16);
            r_z    <= {{(pfet_pkg::Z_W-24){w_a3[15]}}, w_a3[15:0], 8'd0};
        end
    end

    assign w_x0 = $signed({{(pfet_pkg::XY_W-32){1'b0}}, r_prod});

    always_comb begin
        o_vec.x = r_flip ? -w_x0 : w_x0;
        o_vec.y = '0;
        o_vec.z = r_z;
    end

    assign o_valid = r_vld;

endmodule

`default_nettype wire

@@ rtl/pfet_cell.sv @@
// one cordic rotation cell with its pipeline register
`timescale 1ns / 1ps
`default_nettype none

module pfet_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic [4:0]                     i_shift,
    input  wire logic signed [pfet_pkg::Z_W-1:0] i_atan,
    input  wire logic                           i_valid,
    input  wire pfet_pkg::t_vec                 i_vec,
    output logic                                o_valid,
    output pfet_pkg::t_vec                      o_vec
);

    logic signed [pfet_pkg::XY_W-1:0] w_x;
    logic signed [pfet_pkg::XY_W-1:0] w_y;
    logic signed [pfet_pkg::Z_W-1:0]  w_z;
    logic signed [pfet_pkg::XY_W-1:0] w_dx;
    logic signed [pfet_pkg::XY_W-1:0] w_dy;
    logic                             r_vld;
    pfet_pkg::t_vec                   r_vec;
    pfet_pkg::t_vec                   n_vec;

    always_comb begin
        w_x  = i_vec.x;
        w_y  = i_vec.y;
        w_z  = i_vec.z;
        w_dx = w_y >>> i_shift;
        w_dy = w_x >>> i_shift;
        if (w_z >= 0) begin
            n_vec.x = w_x - w_dx;
            n_vec.y = w_y + w_dy;
            n_vec.z = w_z - i_atan;
        end else begin
            n_vec.x = w_x + w_dx;
            n_vec.y = w_y - w_dy;
            n_vec.z = w_z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_vld;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

@@ rtl/pfet_time.sv @@
// time digit split, second of day and elapsed time against the stored record
`timescale 1ns / 1ps
`default_nettype none

module pfet_time (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [pfet_pkg::TRACK_W-1:0]  i_track_id,
    input  wire logic [17:0]                   i_time_hhmmss,
    output pfet_pkg::t_tinfo                   o_info
);

    logic [4:0]  r_vld;

    logic [36:0] w_q;
    logic [17:0] r0_t;
    logic [4:0]  r0_h;
    logic [pfet_pkg::TRACK_W-1:0] r0_id;

    logic [17:0] w_h10k;
    logic [13:0] r1_r;
    logic [4:0]  r1_h;
    logic [pfet_pkg::TRACK_W-1:0] r1_id;

    logic [26:0] w_mp;
    logic [13:0] r2_r;
    logic [6:0]  r2_m;
    logic [4:0]  r2_h;
    logic [pfet_pkg::TRACK_W-1:0] r2_id;

    logic [13:0] w_s;
    logic [6:0]  r3_m;
    logic [6:0]  r3_s;
    logic [4:0]  r3_h;
    logic        r3_inv;
    logic [pfet_pkg::TRACK_W-1:0] r3_id;

    logic [16:0] r4_now;
    logic [4:0]  r4_h;
    logic [5:0]  r4_m;
    logic [5:0]  r4_s;
    logic        r4_inv;
    logic [pfet_pkg::TRACK_W-1:0] r4_id;

    logic [pfet_pkg::ID_CMP_W-1:0] r_last_id;
    logic [16:0]                   r_last_sec;
    logic [16:0]                   n_elapsed;
    pfet_pkg::t_tinfo              r_info;

    assign w_q    = 37'(i_time_hhmmss) * 37'(pfet_pkg::DIV10K_MUL);
    assign w_h10k = 18'(r0_h) * 18'd10000;
    assign w_mp   = 27'(r1_r) * 27'(pfet_pkg::DIV100_MUL);
    assign w_s    = r2_r - 14'(r2_m) * 14'd100;

    always_comb begin
        n_elapsed = '0;
        if (!r4_inv && (r4_id[pfet_pkg::ID_CMP_W-1:0] == r_last_id)) begin
            if (r_last_sec <= r4_now) begin
                n_elapsed = r4_now - r_last_sec;
            end else begin
                n_elapsed = 17'(pfet_pkg::DAY_SEC) - r_last_sec + r4_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_last_id  <= '0;
            r_last_sec <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
            if (r_vld[4]) begin
                r_last_id <= r4_id[pfet_pkg::ID_CMP_W-1:0];
                if (!r4_inv) begin
                    r_last_sec <= r4_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_t  <= i_time_hhmmss;
            r0_h  <= w_q[36:32];
            r0_id <= i_track_id;

            r1_r  <= 14'(r0_t - w_h10k);
            r1_h  <= r0_h;
            r1_id <= r0_id;

            r2_r  <= r1_r;
            r2_m  <= w_mp[25:19];
            r2_h  <= r1_h;
            r2_id <= r1_id;

            r3_m   <= r2_m;
            r3_s   <= w_s[6:0];
            r3_h   <= r2_h;
            r3_inv <= (r2_m > 7'd59) || (w_s[6:0] > 7'd59) || (r2_h > 5'd23);
            r3_id  <= r2_id;

            r4_now <= 17'(r3_h) * 17'd3600 + 17'(r3_m) * 17'd60 + 17'(r3_s);
            r4_h   <= r3_h;
            r4_m   <= (r3_m > 7'd63) ? 6'd63 : r3_m[5:0];
            r4_s   <= (r3_s > 7'd63) ? 6'd63 : r3_s[5:0];
            r4_inv <= r3_inv;
            r4_id  <= r3_id;

            r_info.id      <= r4_id;
            r_info.hour    <= r4_h;
            r_info.minute  <= r4_m;
            r_info.second  <= r4_s;
            r_info.elapsed <= n_elapsed;
            r_info.invalid <= r4_inv;
        end
    end

    assign o_info = r_info;

endmodule

`default_nettype wire

@@ rtl/polar_fix_with_elapsed_time_top.sv @@
// top level: polar to rectangular cordic chain with record time and elapsed seconds
// throughput: one beat per cycle while the output does not hold the pipeline, one cordic cell per stage
// the whole pipeline holds while a result waits at the output register
// reset: synchronous active low, empties the pipeline, clears last id and time
`timescale 1ns / 1ps
`default_nettype none

module polar_fix_with_elapsed_time_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_track_id,
    input  wire logic [17:0] i_time_hhmmss,
    input  wire logic [16:0] i_heading,
    input  wire logic [15:0] i_distance,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_track_id_out,
    output logic [4:0]       o_hour_part,
    output logic [5:0]       o_minute_part,
    output logic [5:0]       o_second_part,
    output logic signed [16:0] o_x_pos,
    output logic signed [16:0] o_y_pos,
    output logic [16:0]      o_elapsed_seconds,
    output logic             o_time_invalid
);

    localparam int N = pfet_pkg::CORDIC_STAGES;
    localparam int D = pfet_pkg::DLY_DEPTH;

    logic             w_en;
    logic             w_acc;
    logic             w_vld [0:N];
    pfet_pkg::t_vec   w_vec [0:N];
    pfet_pkg::t_tinfo w_info;
    pfet_pkg::t_tinfo r_dly [0:D-1];

    logic              r_out_vld;
    pfet_pkg::t_tinfo  r_out_info;
    logic signed [16:0] r_x;
    logic signed [16:0] r_y;

    function automatic logic signed [16:0] sat_q88(input logic signed [pfet_pkg::XY_W-1:0] v);
        logic signed [pfet_pkg::XY_W-1:0] r;
        logic signed [pfet_pkg::XY_W-1:0] hi;
        r  = (v + pfet_pkg::XY_W'(32768)) >>> 16;
        hi = pfet_pkg::XY_W'(pfet_pkg::Q8_MAX);
        if (r > hi) begin
            return 17'(pfet_pkg::Q8_MAX);
        end else if (r < -hi) begin
            return -17'(pfet_pkg::Q8_MAX);
        end
        return r[16:0];
    endfunction

    assign w_en       = !r_out_vld || i_out_ready;
    assign w_acc      = i_in_valid && w_en;
    assign o_in_ready = w_en;

    pfet_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_acc),
        .i_heading  (i_heading),
        .i_distance (i_distance),
        .o_valid    (w_vld[0]),
        .o_vec      (w_vec[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        pfet_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (5'(g)),
            .i_atan  (pfet_pkg::atan_deg16(5'(g))),
            .i_valid (w_vld[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_vld[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    pfet_time u_time (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_acc),
        .i_track_id    (i_track_id),
        .i_time_hhmmss (i_time_hhmmss),
        .o_info        (w_info)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= w_info;
            for (int k = 1; k < D; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_info <= r_dly[D-1];
            r_x        <= sat_q88(w_vec[N].x);
            r_y        <= sat_q88(w_vec[N].y);
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_track_id_out    = r_out_info.id;
    assign o_hour_part       = r_out_info.hour;
    assign o_minute_part     = r_out_info.minute;
    assign o_second_part     = r_out_info.second;
    assign o_x_pos           = r_x;
    assign o_y_pos           = r_y;
    assign o_elapsed_seconds = r_out_info.elapsed;
    assign o_time_invalid    = r_out_info.invalid;

endmodule

`default_nettype wire

@@ tb/polar_fix_checker.sv @@
// checker for the polar fix block: predicts each result beat and compares it field by field
`timescale 1ns / 1ps

module polar_fix_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_track_id,
    input  wire logic [17:0] i_time_hhmmss,
    input  wire logic [16:0] i_heading,
    input  wire logic [15:0] i_distance,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_track_id_out,
    input  wire logic [4:0]  i_hour_part,
    input  wire logic [5:0]  i_minute_part,
    input  wire logic [5:0]  i_second_part,
    input  wire logic signed [16:0] i_x_pos,
    input  wire logic signed [16:0] i_y_pos,
    input  wire logic [16:0] i_elapsed_seconds,
    input  wire logic        i_time_invalid,
    output int               o_mismatches,
    output int               o_pending
);

    typedef struct packed {
        logic [7:0]         id;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [16:0]        elapsed;
        logic               invalid;
    } t_fix;

    longint arctan_steps [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    t_fix                          expected_fixes [$];
    logic [pfet_pkg::ID_CMP_W-1:0] prev_track;
    int unsigned                   prev_second_of_day;
    int                            mismatch_count;

    initial begin
        mismatch_count = 0;
        o_mismatches   = 0;
        o_pending      = 0;
    end

    function automatic logic signed [16:0] round_to_q88(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > pfet_pkg::Q8_MAX)
            r = pfet_pkg::Q8_MAX;
        if (r < -pfet_pkg::Q8_MAX)
            r = -pfet_pkg::Q8_MAX;
        return r[16:0];
    endfunction

    function automatic void rotate_to_xy(input logic [16:0] hdg, input logic [15:0] radius,
                                         output logic signed [16:0] xq,
                                         output logic signed [16:0] yq);
        longint ang, cx, cy, cz, dx, dy;
        bit     flip;
        int     stage;
        ang  = longint'(hdg) % pfet_pkg::FULL_TURN;
        flip = 1'b0;
        if (ang >= pfet_pkg::HALF_TURN)
            ang -= pfet_pkg::FULL_TURN;
        if (ang > pfet_pkg::QUARTER_TURN) begin
            ang -= pfet_pkg::HALF_TURN;
            flip = 1'b1;
        end else if (ang < -pfet_pkg::QUARTER_TURN) begin
            ang += pfet_pkg::HALF_TURN;
            flip = 1'b1;
        end
        cx = longint'(radius) * pfet_pkg::GAIN_Q16;
        if (flip)
            cx = -cx;
        cy = 0;
        cz = ang * 256;
        for (stage = 0; stage < pfet_pkg::CORDIC_STAGES && stage < 24; stage++) begin
            dx = cy >>> stage;
            dy = cx >>> stage;
            if (cz >= 0) begin
                cx -= dx;
                cy += dy;
                cz -= arctan_steps[stage];
            end else begin
                cx += dx;
                cy -= dy;
                cz += arctan_steps[stage];
            end
        end
        xq = round_to_q88(cx);
        yq = round_to_q88(cy);
    endfunction

    // also advances the stored id, and the stored time of day when the time digits are valid
    function automatic t_fix predict_fix(input logic [7:0] id, input logic [17:0] hhmmss,
                                         input logic [16:0] hdg, input logic [15:0] radius);
        t_fix        res;
        int unsigned hr, mn, sc, now;
        bit          bad;
        hr  = hhmmss / 10000;
        mn  = (hhmmss % 10000) / 100;
        sc  = hhmmss % 100;
        bad = (mn > 59) || (sc > 59) || (hr > 23);
        res.id      = id;
        res.hour    = hr[4:0];
        res.minute  = (mn > 63) ? 6'd63 : mn[5:0];
        res.second  = (sc > 63) ? 6'd63 : sc[5:0];
        res.invalid = bad;
        res.elapsed = '0;
        rotate_to_xy(hdg, radius, res.x, res.y);
        if (!bad) begin
            now = hr * 3600 + mn * 60 + sc;
            if (id[pfet_pkg::ID_CMP_W-1:0] == prev_track) begin
                if (prev_second_of_day <= now)
                    res.elapsed = 17'(now - prev_second_of_day);
                else
                    res.elapsed = 17'(pfet_pkg::DAY_SEC - prev_second_of_day + now);
            end
            prev_second_of_day = now;
        end
        prev_track = id[pfet_pkg::ID_CMP_W-1:0];
        return res;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    endtask

    task automatic compare_fix(input t_fix want, input t_fix got);
        if (got.id !== want.id)
            note_mismatch("track_id_out", want.id, got.id);
        if (got.hour !== want.hour)
            note_mismatch("hour_part", want.hour, got.hour);
        if (got.minute !== want.minute)
            note_mismatch("minute_part", want.minute, got.minute);
        if (got.second !== want.second)
            note_mismatch("second_part", want.second, got.second);
        if (got.x !== want.x)
            note_mismatch("x_pos", want.x, got.x);
        if (got.y !== want.y)
            note_mismatch("y_pos", want.y, got.y);
        if (got.elapsed !== want.elapsed)
            note_mismatch("elapsed_seconds", want.elapsed, got.elapsed);
        if (got.invalid !== want.invalid)
            note_mismatch("time_invalid", want.invalid, got.invalid);
    endtask

    always @(posedge i_clk) begin
        t_fix got;
        if (!i_rst_n) begin
            expected_fixes.delete();
            prev_track         = '0;
            prev_second_of_day = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.id      = i_track_id_out;
                got.hour    = i_hour_part;
                got.minute  = i_minute_part;
                got.second  = i_second_part;
                got.x       = i_x_pos;
                got.y       = i_y_pos;
                got.elapsed = i_elapsed_seconds;
                got.invalid = i_time_invalid;
                if (expected_fixes.size() == 0)
                    note_mismatch("unexpected beat, track_id_out", -1, got.id);
                else
                    compare_fix(expected_fixes.pop_front(), got);
            end
            if (i_in_valid && i_in_ready)
                expected_fixes.push_back(predict_fix(i_track_id, i_time_hhmmss,
                                                     i_heading, i_distance));
        end
        o_mismatches = mismatch_count;
        o_pending    = expected_fixes.size();
    end

endmodule

@@ tb/testbench.sv @@
// testbench top: drives position records into the polar fix block and gives the verdict
`timescale 1ns / 1ps

module testbench;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_track_id      = '0;
    logic [17:0]       i_time_hhmmss   = '0;
    logic [16:0]       i_heading       = '0;
    logic [15:0]       i_distance      = '0;
    logic              o_out_valid;
    logic              i_out_ready     = 1'b0;
    logic [7:0]        o_track_id_out;
    logic [4:0]        o_hour_part;
    logic [5:0]        o_minute_part;
    logic [5:0]        o_second_part;
    logic signed [16:0] o_x_pos;
    logic signed [16:0] o_y_pos;
    logic [16:0]       o_elapsed_seconds;
    logic              o_time_invalid;

    int mismatches;
    int pending;
    int tx_idle_pct = 17;
    int rx_idle_pct = 69;

    polar_fix_with_elapsed_time_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_track_id        (i_track_id),
        .i_time_hhmmss     (i_time_hhmmss),
        .i_heading         (i_heading),
        .i_distance        (i_distance),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_track_id_out    (o_track_id_out),
        .o_hour_part       (o_hour_part),
        .o_minute_part     (o_minute_part),
        .o_second_part     (o_second_part),
        .o_x_pos           (o_x_pos),
        .o_y_pos           (o_y_pos),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_time_invalid    (o_time_invalid)
    );

    polar_fix_checker fix_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_track_id        (i_track_id),
        .i_time_hhmmss     (i_time_hhmmss),
        .i_heading         (i_heading),
        .i_distance        (i_distance),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_track_id_out    (o_track_id_out),
        .i_hour_part       (o_hour_part),
        .i_minute_part     (o_minute_part),
        .i_second_part     (o_second_part),
        .i_x_pos           (o_x_pos),
        .i_y_pos           (o_y_pos),
        .i_elapsed_seconds (o_elapsed_seconds),
        .i_time_invalid    (o_time_invalid),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_record(input logic [7:0] id, input logic [17:0] hhmmss,
                               input logic [16:0] hdg, input logic [15:0] radius);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_track_id    <= id;
        i_time_hhmmss <= hhmmss;
        i_heading     <= hdg;
        i_distance    <= radius;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // runs of one track with advancing times, mixed with bad time digits
    task automatic send_random_tracks(input int n_items);
        int          sent;
        int          run_len;
        int unsigned sod;
        logic [7:0]  id;
        logic [17:0] hhmmss;
        logic [16:0] hdg;
        logic [15:0] radius;
        sent = 0;
        while (sent < n_items) begin
            id      = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            run_len = $urandom_range(1, 6);
            sod     = $urandom_range(pfet_pkg::DAY_SEC - 1);
            repeat (run_len) begin
                sod = (sod + $urandom_range(0, 5000)) % pfet_pkg::DAY_SEC;
                case ($urandom_range(9))
                    0: hhmmss = 18'($urandom);
                    1: hhmmss = 18'($urandom_range(23) * 10000 + $urandom_range(60, 99) * 100
                                    + $urandom_range(99));
                    2: hhmmss = 18'($urandom_range(23) * 10000 + $urandom_range(59) * 100
                                    + $urandom_range(60, 99));
                    default: hhmmss = 18'((sod / 3600) * 10000 + ((sod / 60) % 60) * 100
                                          + sod % 60);
                endcase
                hdg = $urandom_range(1) ? 17'($urandom)
                                        : 17'($urandom_range(pfet_pkg::FULL_TURN - 1));
                case ($urandom_range(3))
                    0: radius = 16'($urandom_range(255));
                    1: radius = 16'hFF00 | 16'($urandom_range(255));
                    default: radius = 16'($urandom);
                endcase
                send_record(id, hhmmss, hdg, radius);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first record against id 0 at midnight
        send_record(8'd0,   18'd000130, 17'd0,      16'd256);
        send_record(8'd0,   18'd000200, 17'd23040,  16'd65535);
        send_record(8'd255, 18'd235959, 17'd46080,  16'd65535);
        send_record(8'd255, 18'd000000, 17'd69120,  16'd65535);
        send_record(8'd255, 18'd000001, 17'd92159,  16'd0);
        // midnight wrap on one track
        send_record(8'd5,   18'd235950, 17'd11520,  16'd65535);
        send_record(8'd5,   18'd000010, 17'd34560,  16'd32768);
        // bad time digits, then elapsed from the last good time
        send_record(8'd7,   18'd120000, 17'd57600,  16'd1000);
        send_record(8'd7,   18'd126000, 17'd80640,  16'd1000);
        send_record(8'd7,   18'd120060, 17'd92160,  16'd1000);
        send_record(8'd7,   18'd240000, 17'd131071, 16'd1000);
        send_record(8'd7,   18'd120100, 17'd115200, 16'd65535);
        send_record(8'd7,   18'd009999, 17'd1,      16'd1);
        send_record(8'd7,   18'd262143, 17'd46079,  16'd65535);
        send_record(8'd7,   18'd120200, 17'd46081,  16'd65535);
        // headings just around the quarter turns
        send_record(8'd9,   18'd000000, 17'd23041,  16'd65535);
        send_record(8'd9,   18'd000000, 17'd69119,  16'd65535);
        send_record(8'd9,   18'd000000, 17'd69121,  16'd65535);
        send_record(8'd9,   18'd000000, 17'd22999,  16'd12345);
        send_record(8'd1,   18'd235959, 17'd100000, 16'd54321);

        send_random_tracks(530);
        tx_idle_pct = 69;
        rx_idle_pct = 17;
        send_random_tracks(530);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_tracks(530);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (pfet_pkg::CORDIC_STAGES + 10) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
